// ----- sv/eur_pkg.sv -----
// ----------------------------------------------------------------------------
// eur_pkg
// Shared types and constants of the ultrasonic echo ranger: phase codes,
// register map, configuration bundle and per-tick event flags.
// ----------------------------------------------------------------------------
package eur_pkg;

  // APB register map: register i at byte address 4*i
  localparam int unsigned APB_ADDR_BITS = 5;
  localparam int unsigned APB_DATA_BITS = 32;

  typedef enum logic [2:0] {
    REG_PRE_LOW    = 3'd0,
    REG_TRIG_HIGH  = 3'd1,
    REG_TIMEOUT    = 3'd2,
    REG_SETTLE     = 3'd3,
    REG_NEAR_LIMIT = 3'd4
  } reg_idx_t;

  // Register reset values
  localparam logic [15:0] PRE_LOW_RESET    = 16'd1000;
  localparam logic [9:0]  TRIG_HIGH_RESET  = 10'd10;
  localparam logic [19:0] TIMEOUT_RESET    = 20'd500000;
  localparam logic [19:0] SETTLE_RESET     = 20'd100000;
  localparam logic [9:0]  NEAR_LIMIT_RESET = 10'd10;

  // Echo time to distance: 58 ticks of echo high per centimeter
  localparam int unsigned SUB_CM_BITS  = 6;
  localparam logic [SUB_CM_BITS-1:0] TICKS_PER_CM = 6'd58;

  // Distance shown before the first capture
  localparam int unsigned DIST_RESET = 99;

  typedef struct packed {
    logic [15:0] pre_low_ticks;
    logic [9:0]  trigger_high_ticks;
    logic [19:0] timeout_ticks;
    logic [19:0] settle_ticks;
    logic [9:0]  near_limit_cm;
  } cfg_t;

  typedef enum logic [4:0] {
    PH_PRE_LOW   = 5'b00001,
    PH_TRIG_HIGH = 5'b00010,
    PH_WAIT_ECHO = 5'b00100,
    PH_ECHO_HIGH = 5'b01000,
    PH_SETTLE    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic timed_out;
    logic measure_done;
    logic trigger_level;
  } evt_t;

endpackage

// ----- sv/eur_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// eur_cfg_regs
// APB register file for the ranger timing and near-limit settings.
// ----------------------------------------------------------------------------
module eur_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [eur_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [eur_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [eur_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output eur_pkg::cfg_t                       cfg
);
  import eur_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pre_low_ticks      <= PRE_LOW_RESET;
      cfg.trigger_high_ticks <= TRIG_HIGH_RESET;
      cfg.timeout_ticks      <= TIMEOUT_RESET;
      cfg.settle_ticks       <= SETTLE_RESET;
      cfg.near_limit_cm      <= NEAR_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_PRE_LOW:    cfg.pre_low_ticks      <= pwdata[15:0];
        REG_TRIG_HIGH:  cfg.trigger_high_ticks <= pwdata[9:0];
        REG_TIMEOUT:    cfg.timeout_ticks      <= pwdata[19:0];
        REG_SETTLE:     cfg.settle_ticks       <= pwdata[19:0];
        REG_NEAR_LIMIT: cfg.near_limit_cm      <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PRE_LOW:    prdata = APB_DATA_BITS'(cfg.pre_low_ticks);
      REG_TRIG_HIGH:  prdata = APB_DATA_BITS'(cfg.trigger_high_ticks);
      REG_TIMEOUT:    prdata = APB_DATA_BITS'(cfg.timeout_ticks);
      REG_SETTLE:     prdata = APB_DATA_BITS'(cfg.settle_ticks);
      REG_NEAR_LIMIT: prdata = APB_DATA_BITS'(cfg.near_limit_cm);
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- sv/eur_ranger.sv -----
// ----------------------------------------------------------------------------
// eur_ranger
// Ranging sequencer: trigger timing, echo edge detect, incremental cm count,
// shared timeout and captured distance. State advances once per tick.
// ----------------------------------------------------------------------------
module eur_ranger #(
  parameter int unsigned TICK_COUNTER_BITS = 20,
  parameter int unsigned DISTANCE_BITS     = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      echo,
  input  eur_pkg::cfg_t             cfg,
  output eur_pkg::evt_t             evt,
  output logic [DISTANCE_BITS-1:0]  distance,
  output logic                      near
);
  import eur_pkg::*;

  localparam logic [TICK_COUNTER_BITS-1:0] CNT_MAX  = '1;
  localparam logic [DISTANCE_BITS-1:0]     DIST_MAX = '1;

  phase_t                       phase, phase_next;
  logic [TICK_COUNTER_BITS-1:0] count, count_next, cnt_inc;
  logic [SUB_CM_BITS-1:0]       sub_cm, sub_cm_next, sub_inc;
  logic [DISTANCE_BITS-1:0]     running_cm, running_cm_next;
  logic [DISTANCE_BITS-1:0]     last_dist, last_dist_next;
  logic                         prev_echo;
  logic                         rise, fall, waiting;

  assign rise    = echo && !prev_echo;
  assign fall    = !echo && prev_echo;
  // saturating tick count
  assign cnt_inc = (count == CNT_MAX) ? count : count + 1'b1;
  assign sub_inc = sub_cm + 1'b1;

  always_comb begin
    phase_next      = phase;
    count_next      = count;
    sub_cm_next     = sub_cm;
    running_cm_next = running_cm;
    last_dist_next  = last_dist;
    evt             = '0;
    waiting         = 1'b0;

    unique case (phase)
      PH_TRIG_HIGH: begin
        evt.trigger_level = 1'b1;
        if (32'(cnt_inc) >= 32'(cfg.trigger_high_ticks)) begin
          count_next = '0;
          phase_next = PH_WAIT_ECHO;
        end else begin
          count_next = cnt_inc;
        end
      end
      PH_WAIT_ECHO: begin
        if (rise) begin
          sub_cm_next     = SUB_CM_BITS'(1);
          running_cm_next = '0;
          phase_next      = PH_ECHO_HIGH;
        end
        waiting = 1'b1;
      end
      PH_ECHO_HIGH: begin
        if (fall) begin
          last_dist_next   = running_cm;
          evt.measure_done = 1'b1;
          phase_next       = PH_SETTLE;
          count_next       = '0;
        end else begin
          if (echo) begin
            if (sub_inc >= TICKS_PER_CM) begin
              sub_cm_next = '0;
              if (running_cm != DIST_MAX) begin
                running_cm_next = running_cm + 1'b1;
              end
            end else begin
              sub_cm_next = sub_inc;
            end
          end
          waiting = 1'b1;
        end
      end
      PH_SETTLE: begin
        if (32'(cnt_inc) >= 32'(cfg.settle_ticks)) begin
          count_next = '0;
          phase_next = PH_PRE_LOW;
        end else begin
          count_next = cnt_inc;
        end
      end
      default: begin
        // pre-trigger low, also recovers from any illegal code
        if (32'(cnt_inc) >= 32'(cfg.pre_low_ticks)) begin
          count_next = '0;
          phase_next = PH_TRIG_HIGH;
        end else begin
          count_next = cnt_inc;
          phase_next = PH_PRE_LOW;
        end
      end
    endcase

    // one timeout spans echo wait and echo high
    if (waiting) begin
      if (32'(cnt_inc) >= 32'(cfg.timeout_ticks)) begin
        evt.timed_out   = 1'b1;
        phase_next      = PH_PRE_LOW;
        count_next      = '0;
        sub_cm_next     = '0;
        running_cm_next = '0;
      end else begin
        count_next = cnt_inc;
      end
    end
  end

  assign distance = last_dist_next;
  assign near     = 32'(last_dist_next) < 32'(cfg.near_limit_cm);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_PRE_LOW;
      count      <= '0;
      sub_cm     <= '0;
      running_cm <= '0;
      last_dist  <= DISTANCE_BITS'(DIST_RESET);
      prev_echo  <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      count      <= count_next;
      sub_cm     <= sub_cm_next;
      running_cm <= running_cm_next;
      last_dist  <= last_dist_next;
      prev_echo  <= echo;
    end
  end

endmodule

// ----- sv/ultrasonic_echo_ranger_core.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Ultrasonic range measurement core: one stream item per microsecond tick in
// (sampled echo pin), one item out (trigger level, distance, event flags).
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid/tready      tdata[0] echo_level
//   m_*      out  tvalid/tready      tdata: trigger, done, distance, near, timeout
//   apb      in   psel/penable       5 registers at 4*i, pready tied high
//
// One item per cycle sustained while m_tready stays high; each item passes from
// input acceptance to result through the input register, then the sequencer
// logic into the result register. The sequencer state loop is the timing bound.
// Reset (rst, synchronous) starts in the pre-trigger low phase with all
// counters cleared and a shown distance of 99 cm.
// A stalled m_tready holds the result; the input register still takes one
// more item, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_core #(
  parameter int unsigned TICK_COUNTER_BITS = 20,
  parameter int unsigned DISTANCE_BITS     = 14
) (
  input  logic                                         clk,
  input  logic                                         rst,
  // slave stream
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  input  logic [7:0]                                   s_tdata,  // [0] echo_level
  // master stream
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // [0] trigger_level, [1] measure_done, [DISTANCE_BITS+1:2] distance_cm,
  // [DISTANCE_BITS+2] object_near, [DISTANCE_BITS+3] timed_out, rest zero
  output logic [((DISTANCE_BITS+4+7)/8)*8-1:0]         m_tdata,
  // configuration
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [eur_pkg::APB_ADDR_BITS-1:0]            paddr,
  input  logic [eur_pkg::APB_DATA_BITS-1:0]            pwdata,
  output logic [eur_pkg::APB_DATA_BITS-1:0]            prdata,
  output logic                                         pready
);
  import eur_pkg::*;

  localparam int unsigned TDATA_BITS = ((DISTANCE_BITS + 4 + 7) / 8) * 8;

  cfg_t                     cfg;
  evt_t                     evt_c, evt_r;
  logic [DISTANCE_BITS-1:0] dist_c, dist_r;
  logic                     near_c, near_r;

  logic in_valid, echo_r, out_valid, advance;

  eur_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Move the held tick through the sequencer when the result slot is free
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  eur_ranger #(
    .TICK_COUNTER_BITS (TICK_COUNTER_BITS),
    .DISTANCE_BITS     (DISTANCE_BITS)
  ) u_ranger (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .echo     (echo_r),
    .cfg      (cfg),
    .evt      (evt_c),
    .distance (dist_c),
    .near     (near_c)
  );

  // Input register: hold the sampled echo until the sequencer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      echo_r <= s_tdata[0];
    end
  end

  // Result register: hold until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      evt_r  <= evt_c;
      dist_r <= dist_c;
      near_r <= near_c;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_BITS'({evt_r.timed_out, near_r, dist_r,
                                 evt_r.measure_done, evt_r.trigger_level});

`ifndef SYNTHESIS
  // Trigger, capture and timeout exclude each other: never two at once
  a_evt_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(evt_r))
    else $error("ranger: more than one event flag in one result");

  // A tick taken by the sequencer always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("ranger: processed tick produced no result");

  // A tick held back by a full result slot keeps its echo sample
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(echo_r)))
    else $error("ranger: held input tick lost or changed");
`endif

endmodule
